// File: sv/bms_pkg.sv
package bms_pkg;

    localparam int unsigned CODE_W    = 4;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned FREQ_W    = 12;
    localparam int unsigned DUR_W     = 8;
    localparam int unsigned DUTY_W    = 10;
    localparam int unsigned POS_W     = 3;
    localparam int unsigned IDX_MAX_W = 7;
    localparam int unsigned ROM_ROWS  = 8;
    localparam int unsigned ROM_SLOTS = 8;
    localparam int unsigned ADDR_W    = 3;
    localparam int unsigned DATA_W    = 32;

    localparam logic [DUTY_W-1:0] DUTY_RESET = 10'd512;

    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    localparam logic REG_TONE_DUTY_LEVEL = 1'b0;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [DUR_W-1:0]  dur;
    } note_t;

    typedef struct packed {
        logic [FREQ_W-1:0] tone_freq_hz;
        logic [DUTY_W-1:0] tone_duty;
        logic              playing;
        logic [POS_W-1:0]  note_position;
        logic              melody_finished;
    } result_t;

    function automatic note_t note_lookup(
        input logic [CODE_W-1:0]    mel,
        input logic [IDX_MAX_W-1:0] idx,
        input int unsigned          max_notes
    );
        note_t e;
        e = '0;
        if (32'(mel) < ROM_ROWS && 32'(idx) < ROM_SLOTS && 32'(idx) < max_notes)
        begin
            case ({mel[2:0], idx[2:0]})
                {3'd0, 3'd0}: e = '{12'd523,  8'd100};
                {3'd0, 3'd1}: e = '{12'd659,  8'd100};
                {3'd0, 3'd2}: e = '{12'd784,  8'd150};
                {3'd1, 3'd0}: e = '{12'd880,  8'd80};
                {3'd1, 3'd1}: e = '{12'd0,    8'd50};
                {3'd1, 3'd2}: e = '{12'd880,  8'd80};
                {3'd2, 3'd0}: e = '{12'd440,  8'd100};
                {3'd2, 3'd1}: e = '{12'd880,  8'd100};
                {3'd3, 3'd0}: e = '{12'd440,  8'd150};
                {3'd3, 3'd1}: e = '{12'd0,    8'd100};
                {3'd3, 3'd2}: e = '{12'd440,  8'd150};
                {3'd4, 3'd0}: e = '{12'd330,  8'd100};
                {3'd4, 3'd1}: e = '{12'd660,  8'd100};
                {3'd5, 3'd0}: e = '{12'd660,  8'd100};
                {3'd5, 3'd1}: e = '{12'd330,  8'd100};
                {3'd6, 3'd0}: e = '{12'd1000, 8'd80};
                {3'd6, 3'd1}: e = '{12'd0,    8'd80};
                {3'd6, 3'd2}: e = '{12'd1000, 8'd80};
                {3'd6, 3'd3}: e = '{12'd0,    8'd80};
                {3'd6, 3'd4}: e = '{12'd1000, 8'd80};
                {3'd7, 3'd0}: e = '{12'd800,  8'd100};
                {3'd7, 3'd1}: e = '{12'd0,    8'd100};
                {3'd7, 3'd2}: e = '{12'd800,  8'd100};
                {3'd7, 3'd3}: e = '{12'd0,    8'd100};
                {3'd7, 3'd4}: e = '{12'd800,  8'd100};
                default:      e = '0;
            endcase
        end
        return e;
    endfunction

endpackage

// File: sv/bms_cfg.sv
module bms_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bms_pkg::ADDR_W-1:0]   paddr,
    input  logic [bms_pkg::DATA_W-1:0]   pwdata,
    output logic [bms_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output logic [bms_pkg::DUTY_W-1:0]   duty_level
);

    logic [bms_pkg::DUTY_W-1:0] duty_level_reg;
    logic [bms_pkg::DUTY_W-1:0] duty_level_next;
    logic                       wr_en;
    logic                       sel_duty;

    assign pready   = 1'b1;
    assign sel_duty = (paddr[bms_pkg::ADDR_W-1] == bms_pkg::REG_TONE_DUTY_LEVEL);
    assign wr_en    = psel && penable && pwrite && pready && sel_duty;

    always_comb
    begin
        duty_level_next = duty_level_reg;
        if (wr_en)
        begin
            duty_level_next = pwdata[bms_pkg::DUTY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_level_reg <= bms_pkg::DUTY_RESET;
        end
        else
        begin
            duty_level_reg <= duty_level_next;
        end
    end

    assign prdata     = sel_duty ? bms_pkg::DATA_W'(duty_level_reg) : '0;
    assign duty_level = duty_level_reg;

endmodule

// File: sv/bms_step.sv
module bms_step #(
    parameter int unsigned NUM_MELODIES = 8,
    parameter int unsigned MAX_NOTES    = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic                         command,
    input  logic [bms_pkg::CODE_W-1:0]   melody_code,
    input  logic [bms_pkg::TIME_W-1:0]   now_ms,
    input  logic [bms_pkg::DUTY_W-1:0]   duty_level,
    output bms_pkg::result_t             result
);

    localparam int unsigned IDX_W = $clog2(MAX_NOTES + 1);

    logic [bms_pkg::CODE_W-1:0] melody_reg, melody_next;
    logic [IDX_W-1:0]           note_index_reg, note_index_next;
    logic [bms_pkg::TIME_W-1:0] stamp_reg, stamp_next;
    logic                       active_reg, active_next;
    logic [bms_pkg::FREQ_W-1:0] freq_reg, freq_next;
    logic                       finished;

    logic [IDX_W-1:0]           idx_inc;
    logic [bms_pkg::TIME_W-1:0] elapsed;
    bms_pkg::note_t             cur_note;
    bms_pkg::note_t             nx_note;
    bms_pkg::note_t             first_note;
    logic [bms_pkg::FREQ_W-1:0] freq_out;

    assign idx_inc = (note_index_reg < IDX_W'(MAX_NOTES)) ?
                     IDX_W'(note_index_reg + 1'b1) : note_index_reg;
    assign elapsed    = now_ms - stamp_reg;
    assign cur_note   = bms_pkg::note_lookup(melody_reg,
                            bms_pkg::IDX_MAX_W'(note_index_reg), MAX_NOTES);
    assign nx_note    = bms_pkg::note_lookup(melody_reg,
                            bms_pkg::IDX_MAX_W'(idx_inc), MAX_NOTES);
    assign first_note = bms_pkg::note_lookup(melody_code, '0, MAX_NOTES);

    always_comb
    begin
        melody_next     = melody_reg;
        note_index_next = note_index_reg;
        stamp_next      = stamp_reg;
        active_next     = active_reg;
        freq_next       = freq_reg;
        finished        = 1'b0;
        if (command == bms_pkg::CMD_START)
        begin
            if (5'(melody_code) < 5'(NUM_MELODIES))
            begin
                melody_next     = melody_code;
                note_index_next = '0;
                active_next     = 1'b1;
                freq_next       = first_note.freq;
                stamp_next      = now_ms;
            end
        end
        else if (active_reg)
        begin
            if (elapsed >= bms_pkg::TIME_W'(cur_note.dur))
            begin
                note_index_next = idx_inc;
                if (nx_note == '0)
                begin
                    active_next = 1'b0;
                    freq_next   = '0;
                    finished    = 1'b1;
                end
                else
                begin
                    freq_next  = nx_note.freq;
                    stamp_next = now_ms;
                end
            end
        end
    end

    assign freq_out = active_next ? freq_next : '0;

    always_comb
    begin
        result.tone_freq_hz    = freq_out;
        result.tone_duty       = (freq_out != '0) ? duty_level : '0;
        result.playing         = active_next;
        result.note_position   = bms_pkg::POS_W'(note_index_next);
        result.melody_finished = finished;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            melody_reg     <= '0;
            note_index_reg <= '0;
            stamp_reg      <= '0;
            active_reg     <= 1'b0;
            freq_reg       <= '0;
        end
        else if (advance)
        begin
            melody_reg     <= melody_next;
            note_index_reg <= note_index_next;
            stamp_reg      <= stamp_next;
            active_reg     <= active_next;
            freq_reg       <= freq_next;
        end
    end

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        note_index_reg <= IDX_W'(MAX_NOTES))
        else $error("note index beyond melody length");

    a_end_drops_active: assert property (@(posedge clk) disable iff (!rst_n)
        advance && finished |=> !active_reg && freq_reg == '0)
        else $error("melody end did not silence the sequencer");

    a_idle_update_holds: assert property (@(posedge clk) disable iff (!rst_n)
        advance && command == bms_pkg::CMD_UPDATE && !active_reg |=>
        $stable(note_index_reg) && $stable(stamp_reg) && !active_reg)
        else $error("update while idle changed state");

endmodule

// File: sv/buzzer_melody_sequencer.sv
// Pipeline: an accepted transaction is held in the input register, then its result
// in the result register; a stalled result output holds it in the input register.
// Throughput: one transaction per cycle unless the result output stalls; next-note
// logic is a single subtract and compare plus note ROM reads between the two registers.
// Reset: asynchronous, active low; idle and silent, duty level 512, no clearing pass.
module buzzer_melody_sequencer #(
    parameter int unsigned NUM_MELODIES = 8,
    parameter int unsigned MAX_NOTES    = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bms_pkg::ADDR_W-1:0]   paddr,
    input  logic [bms_pkg::DATA_W-1:0]   pwdata,
    output logic [bms_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  logic                         command,
    input  logic [bms_pkg::CODE_W-1:0]   melody_code,
    input  logic [bms_pkg::TIME_W-1:0]   now_ms,
    output logic                         res_valid,
    input  logic                         res_ready,
    output logic [bms_pkg::FREQ_W-1:0]   tone_freq_hz,
    output logic [bms_pkg::DUTY_W-1:0]   tone_duty,
    output logic                         playing,
    output logic [bms_pkg::POS_W-1:0]    note_position,
    output logic                         melody_finished
);

    logic                       s1_valid_reg, s1_valid_next;
    logic                       s1_command_reg;
    logic [bms_pkg::CODE_W-1:0] s1_code_reg;
    logic [bms_pkg::TIME_W-1:0] s1_now_reg;
    logic                       res_valid_reg, res_valid_next;
    bms_pkg::result_t           res_reg;
    bms_pkg::result_t           step_result;
    logic [bms_pkg::DUTY_W-1:0] duty_level;
    logic                       advance;
    logic                       cmd_take;

    bms_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .duty_level (duty_level)
    );

    bms_step #(
        .NUM_MELODIES (NUM_MELODIES),
        .MAX_NOTES    (MAX_NOTES)
    ) u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .command     (s1_command_reg),
        .melody_code (s1_code_reg),
        .now_ms      (s1_now_reg),
        .duty_level  (duty_level),
        .result      (step_result)
    );

    assign advance   = s1_valid_reg && (!res_valid_reg || res_ready);
    assign cmd_ready = !s1_valid_reg || advance;
    assign cmd_take  = cmd_valid && cmd_ready;

    always_comb
    begin
        s1_valid_next = cmd_take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        res_valid_next = advance ? 1'b1 : (res_ready ? 1'b0 : res_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            s1_command_reg <= command;
            s1_code_reg    <= melody_code;
            s1_now_reg     <= now_ms;
        end
        if (advance)
        begin
            res_reg <= step_result;
        end
    end

    assign res_valid       = res_valid_reg;
    assign tone_freq_hz    = res_reg.tone_freq_hz;
    assign tone_duty       = res_reg.tone_duty;
    assign playing         = res_reg.playing;
    assign note_position   = res_reg.note_position;
    assign melody_finished = res_reg.melody_finished;

    a_result_follows_advance: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("advanced transaction produced no result");

    a_duty_needs_tone: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.tone_duty != '0 |->
        res_reg.tone_freq_hz != '0 && res_reg.playing)
        else $error("duty driven without a sounding tone");

endmodule

// File: tb/buzzer_melody_sequencer_test.sv
`timescale 1ns / 1ps

module buzzer_melody_sequencer_test;

    localparam int unsigned NUM_TUNES   = 8;
    localparam int unsigned MAX_NOTES   = 8;
    localparam int unsigned TUNE_SLOTS  = 6;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASE_ITEMS = 450;

    localparam logic [bms_pkg::ADDR_W-1:0] DUTY_ADDR = {bms_pkg::REG_TONE_DUTY_LEVEL, 2'b00};

    localparam int unsigned TUNE_HZ [NUM_TUNES][TUNE_SLOTS] = '{
        '{523, 659, 784, 0, 0, 0},
        '{880, 0, 880, 0, 0, 0},
        '{440, 880, 0, 0, 0, 0},
        '{440, 0, 440, 0, 0, 0},
        '{330, 660, 0, 0, 0, 0},
        '{660, 330, 0, 0, 0, 0},
        '{1000, 0, 1000, 0, 1000, 0},
        '{800, 0, 800, 0, 800, 0}
    };

    localparam int unsigned TUNE_MS [NUM_TUNES][TUNE_SLOTS] = '{
        '{100, 100, 150, 0, 0, 0},
        '{80, 50, 80, 0, 0, 0},
        '{100, 100, 0, 0, 0, 0},
        '{150, 100, 150, 0, 0, 0},
        '{100, 100, 0, 0, 0, 0},
        '{100, 100, 0, 0, 0, 0},
        '{80, 80, 80, 80, 80, 0},
        '{100, 100, 100, 100, 100, 0}
    };

    logic                         clk;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [bms_pkg::ADDR_W-1:0]   paddr;
    logic [bms_pkg::DATA_W-1:0]   pwdata;
    logic [bms_pkg::DATA_W-1:0]   prdata;
    logic                         pready;
    logic                         cmd_valid;
    logic                         cmd_ready;
    logic                         command;
    logic [bms_pkg::CODE_W-1:0]   melody_code;
    logic [bms_pkg::TIME_W-1:0]   now_ms;
    logic                         res_valid;
    logic                         res_ready;
    logic [bms_pkg::FREQ_W-1:0]   tone_freq_hz;
    logic [bms_pkg::DUTY_W-1:0]   tone_duty;
    logic                         playing;
    logic [bms_pkg::POS_W-1:0]    note_position;
    logic                         melody_finished;

    logic [2:0]                   tune_sel   = '0;
    int unsigned                  tune_pos   = 0;
    logic [bms_pkg::TIME_W-1:0]   note_stamp = '0;
    bit                           tune_on    = 1'b0;
    logic [bms_pkg::FREQ_W-1:0]   tone_hz    = '0;
    logic [bms_pkg::DUTY_W-1:0]   duty_level = bms_pkg::DUTY_RESET;

    bms_pkg::result_t             tones_due [$];
    bms_pkg::result_t             tone_want;
    logic [bms_pkg::TIME_W-1:0]   wall_ms = '0;

    int unsigned         send_idle_pct  = 0;
    int unsigned         recv_stall_pct = 0;
    int unsigned         hold_off_left  = 0;
    int unsigned         items_sent     = 0;
    int unsigned         results_seen   = 0;
    int unsigned         endings_seen   = 0;
    int unsigned         input_stalls   = 0;
    int unsigned         error_count    = 0;
    int unsigned         cycle_count    = 0;

    buzzer_melody_sequencer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .command         (command),
        .melody_code     (melody_code),
        .now_ms          (now_ms),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .tone_freq_hz    (tone_freq_hz),
        .tone_duty       (tone_duty),
        .playing         (playing),
        .note_position   (note_position),
        .melody_finished (melody_finished)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int unsigned tune_note_hz(input logic [2:0] mel, input int unsigned idx);
        if (idx < TUNE_SLOTS && idx < MAX_NOTES)
            return TUNE_HZ[mel][idx];
        return 0;
    endfunction

    function automatic int unsigned tune_note_ms(input logic [2:0] mel, input int unsigned idx);
        if (idx < TUNE_SLOTS && idx < MAX_NOTES)
            return TUNE_MS[mel][idx];
        return 0;
    endfunction

    function automatic void predict_tone(input logic cmd,
                                         input logic [bms_pkg::CODE_W-1:0] code,
                                         input logic [bms_pkg::TIME_W-1:0] now);
        bms_pkg::result_t           r;
        logic [bms_pkg::TIME_W-1:0] elapsed;
        bit                         done;
        done = 1'b0;
        if (cmd == bms_pkg::CMD_START)
        begin
            if (code < NUM_TUNES)
            begin
                tune_sel   = code[2:0];
                tune_pos   = 0;
                tune_on    = 1'b1;
                tone_hz    = bms_pkg::FREQ_W'(tune_note_hz(tune_sel, 0));
                note_stamp = now;
            end
        end
        else if (tune_on)
        begin
            elapsed = now - note_stamp;
            if (elapsed >= tune_note_ms(tune_sel, tune_pos))
            begin
                if (tune_pos < MAX_NOTES)
                    tune_pos++;
                if (tune_note_hz(tune_sel, tune_pos) == 0 && tune_note_ms(tune_sel, tune_pos) == 0)
                begin
                    tune_on = 1'b0;
                    tone_hz = '0;
                    done    = 1'b1;
                end
                else
                begin
                    tone_hz    = bms_pkg::FREQ_W'(tune_note_hz(tune_sel, tune_pos));
                    note_stamp = now;
                end
            end
        end
        r.tone_freq_hz    = tune_on ? tone_hz : '0;
        r.tone_duty       = (r.tone_freq_hz != 0) ? duty_level : '0;
        r.playing         = tune_on;
        r.note_position   = tune_pos[2:0];
        r.melody_finished = done;
        tones_due.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    task automatic send_item(input logic cmd, input logic [bms_pkg::CODE_W-1:0] code,
                             input logic [bms_pkg::TIME_W-1:0] now);
        @(negedge clk);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        command     <= cmd;
        melody_code <= code;
        now_ms      <= now;
        cmd_valid   <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (cmd_ready)
                break;
            input_stalls++;
        end
        predict_tone(cmd, code, now);
        items_sent++;
    endtask

    // drop valid and wait for the pipeline to empty
    task automatic settle();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (tones_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_duty_level(input logic [bms_pkg::DUTY_W-1:0] level);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DUTY_ADDR;
        pwdata  <= bms_pkg::DATA_W'(level);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        duty_level = level;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== bms_pkg::DATA_W'(level))
            report_mismatch("duty level read-back", prdata, level);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        res_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                res_ready <= 1'b0;
            end
            else
                res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            results_seen++;
            if (melody_finished === 1'b1)
                endings_seen++;
            if (tones_due.size() == 0)
                report_mismatch("result with nothing outstanding", tone_freq_hz, 0);
            else
            begin
                tone_want = tones_due.pop_front();
                if (tone_freq_hz !== tone_want.tone_freq_hz)
                    report_mismatch("tone_freq_hz", tone_freq_hz, tone_want.tone_freq_hz);
                if (tone_duty !== tone_want.tone_duty)
                    report_mismatch("tone_duty", tone_duty, tone_want.tone_duty);
                if (playing !== tone_want.playing)
                    report_mismatch("playing", playing, tone_want.playing);
                if (note_position !== tone_want.note_position)
                    report_mismatch("note_position", note_position, tone_want.note_position);
                if (melody_finished !== tone_want.melody_finished)
                    report_mismatch("melody_finished", melody_finished,
                                    tone_want.melody_finished);
            end
        end
    end

    task automatic test_idle_and_ignored();
        send_item(bms_pkg::CMD_UPDATE, 4'd0, 32'h0000_0000);
        send_item(bms_pkg::CMD_UPDATE, 4'd15, 32'hFFFF_FFFF);
        send_item(bms_pkg::CMD_START, 4'd15, 32'h1234_5678);
        send_item(bms_pkg::CMD_START, 4'd8, 32'h0000_0000);
    endtask

    task automatic test_wrap_to_end();
        logic [bms_pkg::TIME_W-1:0] base;
        base = 32'hFFFF_FFC0;
        send_item(bms_pkg::CMD_START, 4'd0, base);
        send_item(bms_pkg::CMD_UPDATE, 4'd0, base + 99);
        send_item(bms_pkg::CMD_UPDATE, 4'd0, base + 100);
        send_item(bms_pkg::CMD_UPDATE, 4'd0, base + 200);
        send_item(bms_pkg::CMD_UPDATE, 4'd0, base + 349);
        send_item(bms_pkg::CMD_UPDATE, 4'd0, base + 350);
        send_item(bms_pkg::CMD_UPDATE, 4'd0, base + 400);
    endtask

    task automatic test_rest_and_restart();
        send_item(bms_pkg::CMD_START, 4'd1, 32'd1000);
        send_item(bms_pkg::CMD_UPDATE, 4'd1, 32'd1080);
        send_item(bms_pkg::CMD_START, 4'd6, 32'd1100);
        send_item(bms_pkg::CMD_START, 4'd12, 32'd1120);
        send_item(bms_pkg::CMD_UPDATE, 4'd6, 32'd1180);
    endtask

    task automatic test_duty_extremes();
        set_duty_level(10'd0);
        send_item(bms_pkg::CMD_START, 4'd7, 32'd5000);
        send_item(bms_pkg::CMD_UPDATE, 4'd7, 32'd5100);
        set_duty_level(10'd1023);
        send_item(bms_pkg::CMD_START, 4'd3, 32'd6000);
        send_item(bms_pkg::CMD_UPDATE, 4'd3, 32'd6150);
    endtask

    task automatic play_session();
        int unsigned                steps;
        int unsigned                pick;
        int unsigned                dur;
        logic [bms_pkg::TIME_W-1:0] elapsed;
        logic [bms_pkg::TIME_W-1:0] remaining;
        logic [bms_pkg::TIME_W-1:0] gap;
        if ($urandom_range(0, 3) == 0)
            wall_ms = $urandom;
        else if ($urandom_range(0, 9) == 0)
            wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
        send_item(bms_pkg::CMD_START, 4'($urandom_range(0, 7)), wall_ms);
        steps = 0;
        while (tune_on && steps < 40)
        begin
            dur       = tune_note_ms(tune_sel, tune_pos);
            elapsed   = wall_ms - note_stamp;
            remaining = (elapsed >= dur) ? '0 : bms_pkg::TIME_W'(dur) - elapsed;
            pick      = $urandom_range(0, 19);
            if (pick < 6)
                gap = (remaining == 0) ? '0 : remaining - 1;
            else if (pick < 12)
                gap = remaining;
            else if (pick < 15)
                gap = remaining + $urandom_range(1, 40);
            else if (pick < 17)
                gap = $urandom_range(0, 20);
            else if (pick == 17)
                gap = $urandom;
            else if (pick == 18)
                gap = -bms_pkg::TIME_W'($urandom_range(1, 50));
            else
            begin
                send_item(bms_pkg::CMD_START, 4'($urandom_range(0, 15)), wall_ms);
                steps++;
                continue;
            end
            wall_ms = wall_ms + gap;
            send_item(bms_pkg::CMD_UPDATE, 4'($urandom), wall_ms);
            steps++;
        end
        if ($urandom_range(0, 1) == 0)
            send_item(bms_pkg::CMD_UPDATE, 4'($urandom), wall_ms + $urandom_range(0, 500));
    endtask

    task automatic run_traffic(input int unsigned goal);
        int unsigned n;
        while (items_sent < goal)
        begin
            if ($urandom_range(0, 9) < 8)
                play_session();
            else
            begin
                n = $urandom_range(1, 4);
                repeat (n) send_item(1'($urandom), 4'($urandom), $urandom);
            end
            if ($urandom_range(0, 39) == 0)
                settle();
        end
    endtask

    task automatic test_random_traffic();
        send_idle_pct  = 8;
        recv_stall_pct = 78;
        set_duty_level(10'($urandom));
        run_traffic(items_sent + PHASE_ITEMS);
        send_idle_pct  = 78;
        recv_stall_pct = 8;
        set_duty_level(10'($urandom));
        run_traffic(items_sent + PHASE_ITEMS);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_duty_level(10'd512);
        run_traffic(items_sent + PHASE_ITEMS);
    endtask

    task automatic test_back_pressure();
        int unsigned n;
        settle();
        @(posedge clk);
        hold_off_left = 300;
        wall_ms = $urandom;
        for (n = 0; n < 60; n++)
        begin
            if (!tune_on)
                send_item(bms_pkg::CMD_START, 4'($urandom_range(0, 7)), wall_ms);
            else
            begin
                wall_ms = wall_ms + $urandom_range(0, 90);
                send_item(bms_pkg::CMD_UPDATE, 4'($urandom), wall_ms);
            end
        end
        settle();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        cmd_valid   = 1'b0;
        command     = bms_pkg::CMD_START;
        melody_code = '0;
        now_ms      = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        test_idle_and_ignored();
        test_wrap_to_end();
        test_rest_and_restart();
        test_duty_extremes();
        test_random_traffic();
        test_back_pressure();
        settle();

        $display("covered %0d transactions, %0d results, %0d melody endings over all eight tunes",
                 items_sent, results_seen, endings_seen);
        $display("restarts, ignored codes, time wrap, duty 0/1023/random; %0d input stall cycles",
                 input_stalls);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: buzzer_melody_sequencer.f
sv/bms_pkg.sv
sv/bms_cfg.sv
sv/bms_step.sv
sv/buzzer_melody_sequencer.sv
tb/buzzer_melody_sequencer_test.sv
